/* hdl/tkws_pkg.sv */
// tkws_pkg: shared types and constants for the top-k windowed subarray sum block
// holds the sequencer state type, push return codes, register indexes and defaults
// no dependencies
`timescale 1ns / 1ps

package tkws_pkg;

    // default sizing
    localparam int DEF_MAX_ITEMS = 1024;
    localparam int DEF_LEVELS    = 11;
    localparam int DEF_MAX_PICKS = 1024;

    // configuration port
    localparam int CFG_W  = 11;
    localparam int CFG_AW = 2;

    localparam logic [CFG_AW-1:0] CFG_COUNT_K = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_MIN_LEN = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_MAX_LEN = 2'd2;

    localparam logic [CFG_W-1:0] RST_COUNT_K = 11'd1;
    localparam logic [CFG_W-1:0] RST_MIN_LEN = 11'd1;
    localparam logic [CFG_W-1:0] RST_MAX_LEN = 11'd1024;

    // sequencer states
    typedef enum logic [4:0] {
        S_INIT,
        S_LOAD,
        S_BLD_RD,
        S_BLD_WR,
        S_SEED,
        S_AM_RD,
        S_AM_CMP,
        S_PV,
        S_SU_RD,
        S_SU_CMP,
        S_PICK,
        S_POP,
        S_SD_RD,
        S_SD_CMP,
        S_SPLIT_L,
        S_SPLIT_R,
        S_OUT
    } t_state;

    // where a push returns to
    typedef enum logic [1:0] {
        RET_SEED,
        RET_LEFT,
        RET_RIGHT
    } t_ret;

endpackage

/* hdl/top_k_window_subarray_sum.sv */
// top_k_window_subarray_sum: samples load one per cycle into a sparse min table
// memory, then a heap memory yields the sum of the count_k (at most MAX_PICKS)
// largest window sums. o_ready is high only while loading, one sample per cycle.
// After the transfer marked last the block builds the sparse table entry by entry,
// then seeds at most one heap candidate per end index and runs the picks.
// A push reads the range argmin, forms the candidate value and sifts up; a pick
// reads top and last, pops, sifts down, looks up the split argmin, makes the split
// decisions and does up to two pushes. Every step goes through the single write
// port of the table memory or the heap memory, so one sequence is worked on at a
// time. The result waits in o_total/o_exhausted until taken; an init state then
// runs before loading resumes. No clearing pass follows reset.
// Depends on tkws_pkg.
`timescale 1ns / 1ps

module top_k_window_subarray_sum #(
    parameter int MAX_ITEMS = tkws_pkg::DEF_MAX_ITEMS,
    parameter int LEVELS    = tkws_pkg::DEF_LEVELS,
    parameter int MAX_PICKS = tkws_pkg::DEF_MAX_PICKS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration writes
    input  logic                        i_cfg_wen,
    input  logic [tkws_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [tkws_pkg::CFG_W-1:0]  i_cfg_wdata,
    // sample channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [15:0]          i_sample,
    input  logic                        i_last,
    // result channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [63:0]          o_total,
    output logic                        o_exhausted
);

    localparam int ROW = MAX_ITEMS + 1;
    localparam int TD  = LEVELS * ROW;
    localparam int TA  = $clog2(TD);
    localparam int IW  = $clog2(MAX_ITEMS + 2);
    localparam int PW  = 17 + $clog2(MAX_ITEMS);
    localparam int VW  = PW + 1;
    localparam int LW  = $clog2(LEVELS + 1);
    localparam int CAP = MAX_ITEMS + MAX_PICKS + 2;
    localparam int HA  = $clog2(CAP);
    localparam int FW  = $clog2(CAP + 1);
    localparam int SW  = HA + 2;
    localparam int CFW = tkws_pkg::CFG_W;
    localparam int AW0 = (IW > CFW) ? IW : CFW;
    localparam int AW  = ((AW0 > LEVELS) ? AW0 : LEVELS) + 1;
    localparam int PKW = $clog2(MAX_PICKS + 1);
    localparam int PCW = (PKW > CFW) ? PKW : CFW;

    typedef struct packed {
        logic [VW-1:0] val;
        logic [IW-1:0] stop;
        logic [IW-1:0] lo;
        logic [IW-1:0] hi;
    } t_hent;

    // table address: level row plus index
    function automatic logic [TA-1:0] taddr(input logic [LW-1:0] lev,
                                            input logic [IW-1:0] idx);
        return TA'(TA'(lev) * TA'(ROW)) + TA'(idx);
    endfunction

    // configuration registers
    logic [CFW-1:0] r_count_k, r_min_len, r_max_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_k <= tkws_pkg::RST_COUNT_K;
            r_min_len <= tkws_pkg::RST_MIN_LEN;
            r_max_len <= tkws_pkg::RST_MAX_LEN;
        end else if (i_cfg_wen) begin
            case (i_cfg_addr)
                tkws_pkg::CFG_COUNT_K: r_count_k <= i_cfg_wdata;
                tkws_pkg::CFG_MIN_LEN: r_min_len <= i_cfg_wdata;
                tkws_pkg::CFG_MAX_LEN: r_max_len <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer registers
    tkws_pkg::t_state r_state, n_state;
    tkws_pkg::t_ret   r_ret, n_ret;
    logic [IW-1:0]    r_cnt, n_cnt;
    logic [PW-1:0]    r_prefix, n_prefix;
    logic [LW-1:0]    r_lev, n_lev;
    logic [AW-1:0]    r_i, n_i;
    logic [FW-1:0]    r_fill, n_fill;
    logic [63:0]      r_acc, n_acc;
    logic [PCW-1:0]   r_done, n_done;
    logic             r_exh, n_exh;
    logic [IW-1:0]    r_pend, n_pend, r_plo, n_plo, r_phi, n_phi;
    logic [IW-1:0]    r_tlo, n_tlo, r_thi, n_thi, r_at, n_at;
    t_hent            r_item, n_item;
    logic [HA-1:0]    r_pos, n_pos;
    logic             r_ampush, n_ampush;

    // table memory ports
    logic [PW-1:0] tmem_v [TD];
    logic [IW-1:0] tmem_i [TD];
    logic [TA-1:0] tra, trb, tw_addr;
    logic          tw_en;
    logic [PW-1:0] tw_v, r_tva, r_tvb;
    logic [IW-1:0] tw_i, r_tia, r_tib;

    // heap memory ports
    t_hent         hmem [CAP];
    logic [HA-1:0] hra, hrb, hw_addr;
    logic          hw_en;
    t_hent         hw_data, r_ha, r_hb;

    // derived values
    logic [CFW-1:0] minl;
    logic [AW-1:0]  am_len;
    logic [LW-1:0]  am_lev;
    logic [IW-1:0]  am_b, am_at, bld_half;
    logic [HA-1:0]  su_parent;
    logic           bld_ok, bld_take;
    logic [PCW-1:0] picks;
    logic [SW-1:0]  sd_l, sd_r;
    logic           use_l, use_r;
    logic [VW-1:0]  bigv;
    tkws_pkg::t_state ret_state;

    assign minl     = (r_min_len == '0) ? CFW'(1) : r_min_len;
    assign am_len   = AW'(r_phi) - AW'(r_plo) + AW'(1);
    assign am_b     = IW'(AW'(r_phi) + AW'(1) - (AW'(1) << am_lev));
    assign am_at    = ($signed(r_tva) < $signed(r_tvb)) ? r_tia : r_tib;
    assign bld_ok   = (r_i + (AW'(1) << r_lev)) <= (AW'(r_cnt) + AW'(1));
    assign bld_half = IW'(r_i + (AW'(1) << (r_lev - LW'(1))));
    assign bld_take = $signed(r_tva) < $signed(r_tvb);
    assign picks    = (PCW'(r_count_k) > PCW'(MAX_PICKS)) ? PCW'(MAX_PICKS)
                                                          : PCW'(r_count_k);
    assign su_parent = (r_pos - HA'(1)) >> 1;
    assign sd_l     = SW'({r_pos, 1'b1});
    assign sd_r     = sd_l + SW'(1);
    assign use_l    = (sd_l < SW'(r_fill)) && ($signed(r_item.val) < $signed(r_ha.val));
    assign bigv     = use_l ? r_ha.val : r_item.val;
    assign use_r    = (sd_r < SW'(r_fill)) && ($signed(bigv) < $signed(r_hb.val));

    // sparse table level for a range length
    always_comb begin
        am_lev = '0;
        for (int k = 1; k < LEVELS; k++) begin
            if ((AW'(1) << k) <= am_len) am_lev = LW'(k);
        end
    end

    // push return target
    always_comb begin
        case (r_ret)
            tkws_pkg::RET_SEED:  ret_state = tkws_pkg::S_SEED;
            tkws_pkg::RET_LEFT:  ret_state = tkws_pkg::S_SPLIT_R;
            tkws_pkg::RET_RIGHT: ret_state = tkws_pkg::S_PICK;
            default:             ret_state = tkws_pkg::S_PICK;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tkws_pkg::S_INIT;
            r_ret    <= tkws_pkg::RET_SEED;
            r_cnt    <= '0;
            r_prefix <= '0;
            r_lev    <= '0;
            r_i      <= '0;
            r_fill   <= '0;
            r_acc    <= '0;
            r_done   <= '0;
            r_exh    <= 1'b0;
            r_pos    <= '0;
            r_ampush <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_cnt    <= n_cnt;
            r_prefix <= n_prefix;
            r_lev    <= n_lev;
            r_i      <= n_i;
            r_fill   <= n_fill;
            r_acc    <= n_acc;
            r_done   <= n_done;
            r_exh    <= n_exh;
            r_pos    <= n_pos;
            r_ampush <= n_ampush;
        end
    end

    // working payload registers
    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_plo  <= n_plo;
        r_phi  <= n_phi;
        r_tlo  <= n_tlo;
        r_thi  <= n_thi;
        r_at   <= n_at;
        r_item <= n_item;
    end

    // next state and memory controls
    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_cnt    = r_cnt;
        n_prefix = r_prefix;
        n_lev    = r_lev;
        n_i      = r_i;
        n_fill   = r_fill;
        n_acc    = r_acc;
        n_done   = r_done;
        n_exh    = r_exh;
        n_pend   = r_pend;
        n_plo    = r_plo;
        n_phi    = r_phi;
        n_tlo    = r_tlo;
        n_thi    = r_thi;
        n_at     = r_at;
        n_item   = r_item;
        n_pos    = r_pos;
        n_ampush = r_ampush;
        tra      = '0;
        trb      = '0;
        tw_en    = 1'b0;
        tw_addr  = '0;
        tw_v     = '0;
        tw_i     = '0;
        hra      = '0;
        hrb      = '0;
        hw_en    = 1'b0;
        hw_addr  = '0;
        hw_data  = r_item;
        case (r_state)
            // entry zero of level zero holds prefix zero
            tkws_pkg::S_INIT: begin
                tw_en    = 1'b1;
                tw_addr  = taddr('0, '0);
                n_cnt    = '0;
                n_prefix = '0;
                n_state  = tkws_pkg::S_LOAD;
            end
            // one sample per transfer into level zero, up to MAX_ITEMS samples
            tkws_pkg::S_LOAD: begin
                if (i_valid) begin
                    if (r_cnt < IW'(MAX_ITEMS)) begin
                        n_prefix = r_prefix + {{(PW-16){i_sample[15]}}, i_sample};
                        n_cnt    = r_cnt + IW'(1);
                        tw_en    = 1'b1;
                        tw_addr  = taddr('0, n_cnt);
                        tw_v     = n_prefix;
                        tw_i     = n_cnt;
                    end
                    if (i_last) begin
                        n_lev   = LW'(1);
                        n_i     = '0;
                        n_state = tkws_pkg::S_BLD_RD;
                    end
                end
            end
            // sparse table build, level by level
            tkws_pkg::S_BLD_RD: begin
                if (r_lev == LW'(LEVELS)) begin
                    n_i     = AW'(minl);
                    n_fill  = '0;
                    n_state = tkws_pkg::S_SEED;
                end else if (bld_ok) begin
                    tra     = taddr(r_lev - LW'(1), IW'(r_i));
                    trb     = taddr(r_lev - LW'(1), bld_half);
                    n_state = tkws_pkg::S_BLD_WR;
                end else begin
                    n_lev = r_lev + LW'(1);
                    n_i   = '0;
                end
            end
            tkws_pkg::S_BLD_WR: begin
                tw_en   = 1'b1;
                tw_addr = taddr(r_lev, IW'(r_i));
                tw_v    = bld_take ? r_tva : r_tvb;
                tw_i    = bld_take ? r_tia : r_tib;
                n_i     = r_i + AW'(1);
                n_state = tkws_pkg::S_BLD_RD;
            end
            // at most one candidate per end index
            tkws_pkg::S_SEED: begin
                if (r_i > AW'(r_cnt)) begin
                    n_done  = '0;
                    n_acc   = '0;
                    n_exh   = 1'b0;
                    n_state = tkws_pkg::S_PICK;
                end else begin
                    n_pend   = IW'(r_i);
                    n_plo    = (r_i > AW'(r_max_len)) ? IW'(r_i - AW'(r_max_len)) : '0;
                    n_phi    = IW'(r_i - AW'(minl));
                    n_ret    = tkws_pkg::RET_SEED;
                    n_ampush = 1'b1;
                    n_i      = r_i + AW'(1);
                    n_state  = tkws_pkg::S_AM_RD;
                end
            end
            // range argmin: two table reads
            tkws_pkg::S_AM_RD: begin
                if (r_ampush && ((r_plo > r_phi) || (r_fill >= FW'(CAP)))) begin
                    n_state = ret_state;
                end else begin
                    tra     = taddr(am_lev, r_plo);
                    trb     = taddr(am_lev, am_b);
                    n_state = tkws_pkg::S_AM_CMP;
                end
            end
            tkws_pkg::S_AM_CMP: begin
                if (r_ampush) begin
                    tra     = taddr('0, r_pend);
                    trb     = taddr('0, am_at);
                    n_state = tkws_pkg::S_PV;
                end else begin
                    n_at    = am_at;
                    n_state = tkws_pkg::S_SPLIT_L;
                end
            end
            // candidate value, then sift-up from the new slot
            tkws_pkg::S_PV: begin
                n_item.val  = {r_tva[PW-1], r_tva} - {r_tvb[PW-1], r_tvb};
                n_item.stop = r_pend;
                n_item.lo   = r_plo;
                n_item.hi   = r_phi;
                n_pos       = HA'(r_fill);
                n_fill      = r_fill + FW'(1);
                n_state     = tkws_pkg::S_SU_RD;
            end
            tkws_pkg::S_SU_RD: begin
                if (r_pos == '0) begin
                    hw_en   = 1'b1;
                    hw_addr = '0;
                    n_state = ret_state;
                end else begin
                    hra     = su_parent;
                    n_state = tkws_pkg::S_SU_CMP;
                end
            end
            tkws_pkg::S_SU_CMP: begin
                hw_en   = 1'b1;
                hw_addr = r_pos;
                if ($signed(r_ha.val) < $signed(r_item.val)) begin
                    hw_data = r_ha;
                    n_pos   = su_parent;
                    n_state = tkws_pkg::S_SU_RD;
                end else begin
                    n_state = ret_state;
                end
            end
            // next pick: read top and last
            tkws_pkg::S_PICK: begin
                if (r_done == picks) begin
                    n_state = tkws_pkg::S_OUT;
                end else if (r_fill == '0) begin
                    n_exh   = 1'b1;
                    n_state = tkws_pkg::S_OUT;
                end else begin
                    hra     = '0;
                    hrb     = HA'(r_fill - FW'(1));
                    n_state = tkws_pkg::S_POP;
                end
            end
            tkws_pkg::S_POP: begin
                n_acc    = r_acc + {{(64-VW){r_ha.val[VW-1]}}, r_ha.val};
                n_done   = r_done + PCW'(1);
                n_fill   = r_fill - FW'(1);
                n_pend   = r_ha.stop;
                n_plo    = r_ha.lo;
                n_phi    = r_ha.hi;
                n_tlo    = r_ha.lo;
                n_thi    = r_ha.hi;
                n_ampush = 1'b0;
                n_item   = r_hb;
                n_pos    = '0;
                n_state  = (r_fill == FW'(1)) ? tkws_pkg::S_AM_RD : tkws_pkg::S_SD_RD;
            end
            // sift-down with the hole at r_pos
            tkws_pkg::S_SD_RD: begin
                hra     = HA'(sd_l);
                hrb     = HA'(sd_r);
                n_state = tkws_pkg::S_SD_CMP;
            end
            tkws_pkg::S_SD_CMP: begin
                hw_en   = 1'b1;
                hw_addr = r_pos;
                if (use_r) begin
                    hw_data = r_hb;
                    n_pos   = HA'(sd_r);
                    n_state = tkws_pkg::S_SD_RD;
                end else if (use_l) begin
                    hw_data = r_ha;
                    n_pos   = HA'(sd_l);
                    n_state = tkws_pkg::S_SD_RD;
                end else begin
                    n_state = tkws_pkg::S_AM_RD;
                end
            end
            // split the popped range around its argmin
            tkws_pkg::S_SPLIT_L: begin
                if (r_at > r_tlo) begin
                    n_plo    = r_tlo;
                    n_phi    = r_at - IW'(1);
                    n_ret    = tkws_pkg::RET_LEFT;
                    n_ampush = 1'b1;
                    n_state  = tkws_pkg::S_AM_RD;
                end else begin
                    n_state = tkws_pkg::S_SPLIT_R;
                end
            end
            tkws_pkg::S_SPLIT_R: begin
                if (r_at < r_thi) begin
                    n_plo    = r_at + IW'(1);
                    n_phi    = r_thi;
                    n_ret    = tkws_pkg::RET_RIGHT;
                    n_ampush = 1'b1;
                    n_state  = tkws_pkg::S_AM_RD;
                end else begin
                    n_state = tkws_pkg::S_PICK;
                end
            end
            // result waits for transfer
            tkws_pkg::S_OUT: begin
                if (i_ready) n_state = tkws_pkg::S_INIT;
            end
            default: n_state = tkws_pkg::S_INIT;
        endcase
    end

    // sparse table memory
    always_ff @(posedge i_clk) begin
        if (tw_en) begin
            tmem_v[tw_addr] <= tw_v;
            tmem_i[tw_addr] <= tw_i;
        end
        r_tva <= tmem_v[tra];
        r_tia <= tmem_i[tra];
        r_tvb <= tmem_v[trb];
        r_tib <= tmem_i[trb];
    end

    // candidate heap memory
    always_ff @(posedge i_clk) begin
        if (hw_en) hmem[hw_addr] <= hw_data;
        r_ha <= hmem[hra];
        r_hb <= hmem[hrb];
    end

    // outputs
    assign o_ready     = (r_state == tkws_pkg::S_LOAD);
    assign o_valid     = (r_state == tkws_pkg::S_OUT);
    assign o_total     = r_acc;
    assign o_exhausted = r_exh;

    // checks
    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(CAP))
        else $error("heap fill beyond capacity");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("load and result active together");

    a_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) |=> (!o_valid && !o_ready))
        else $error("no restart cycle after result transfer");

    a_hole_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tkws_pkg::S_SD_RD) |-> (FW'(r_pos) < r_fill))
        else $error("sift-down hole outside heap");

endmodule
